>>> rtl/core/jse_pkg.sv
package jse_pkg;

  localparam int MaxChars = 8;
  localparam int EscChars = 6;
  localparam int CntW     = $clog2(MaxChars + 1);
  localparam int IdxW     = $clog2(MaxChars);
  localparam int EscIdxW  = $clog2(EscChars);

  typedef logic [7:0] char_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [IdxW-1:0] idx_t;
  typedef char_t [MaxChars-1:0] char_list_t;
  typedef char_t [EscChars-1:0] esc_list_t;

  localparam char_t CharQuote  = 8'h22;
  localparam char_t CharBslash = 8'h5C;
  localparam char_t CharU      = 8'h75;
  localparam char_t CharZero   = 8'h30;
  localparam char_t CharUpperA = 8'h41;
  localparam char_t CtrlLimit  = 8'h20;

  localparam char_t CodeBs  = 8'h08;
  localparam char_t CodeTab = 8'h09;
  localparam char_t CodeLf  = 8'h0A;
  localparam char_t CodeFf  = 8'h0C;
  localparam char_t CodeCr  = 8'h0D;

  localparam char_t LetterB = 8'h62;
  localparam char_t LetterF = 8'h66;
  localparam char_t LetterN = 8'h6E;
  localparam char_t LetterR = 8'h72;
  localparam char_t LetterT = 8'h74;

  function automatic char_t hex_digit(input logic [3:0] d);
    if (d < 4'd10) begin
      return CharZero + {4'd0, d};
    end
    return CharUpperA + {4'd0, d} - 8'd10;
  endfunction

endpackage

>>> rtl/core/json_string_escaper_unit.sv
// Path: input register, expanded character list, serializer, output register.
// Throughput: one input word per cycle while each word yields one character
// and char_stall is low; an n-character word holds the serializer until all n are sent.
// Words yielding no characters are dropped in the decode stage.
// Reset (synchronous, active high) clears all stage valid bits.
module json_string_escaper_unit
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] data_byte,
  input  logic       has_byte,
  input  logic       start_of_string,
  input  logic       end_of_string,
  input  logic       data_valid,
  output logic       data_stall,
  output logic [7:0] out_char,
  output logic       last_of_run,
  output logic       char_valid,
  input  logic       char_stall
);

  // stage 1: input register
  logic  s1_valid;
  char_t s1_byte;
  logic  s1_has;
  logic  s1_start;
  logic  s1_end;

  // stage 2: expanded character list
  logic       s2_valid;
  char_list_t s2_chars;
  cnt_t       s2_cnt;

  // stage 3: serializer
  logic       ser_valid;
  char_list_t ser_chars;
  cnt_t       ser_cnt;
  idx_t       ser_idx;

  logic out_ready;
  logic ser_last;
  logic ser_ready;
  logic s2_ready;
  logic s1_ready;

  esc_list_t  esc;
  logic [2:0] esc_n;
  logic       short_esc;
  char_t      letter;
  char_list_t chars_next;
  cnt_t       cnt_next;
  cnt_t       pos;

  assign out_ready  = !char_valid || !char_stall;
  assign ser_last   = ({1'b0, ser_idx} == (ser_cnt - cnt_t'(1)));
  assign ser_ready  = !ser_valid || (out_ready && ser_last);
  assign s2_ready   = !s2_valid || ser_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign data_stall = !s1_ready;

  always_comb begin
    short_esc = 1'b1;
    letter    = s1_byte;
    unique case (s1_byte)
      CharQuote:  letter = CharQuote;
      CharBslash: letter = CharBslash;
      CodeBs:     letter = LetterB;
      CodeFf:     letter = LetterF;
      CodeLf:     letter = LetterN;
      CodeCr:     letter = LetterR;
      CodeTab:    letter = LetterT;
      default:    short_esc = 1'b0;
    endcase

    esc = '{default: CharZero};
    if (short_esc) begin
      esc[0] = CharBslash;
      esc[1] = letter;
      esc_n  = 3'd2;
    end else if (s1_byte < CtrlLimit) begin
      esc[0] = CharBslash;
      esc[1] = CharU;
      esc[2] = CharZero;
      esc[3] = CharZero;
      esc[4] = hex_digit(s1_byte[7:4]);
      esc[5] = hex_digit(s1_byte[3:0]);
      esc_n  = 3'd6;
    end else begin
      esc[0] = s1_byte;
      esc_n  = 3'd1;
    end
    if (!s1_has) begin
      esc_n = 3'd0;
    end

    cnt_next = cnt_t'(s1_start) + cnt_t'(esc_n) + cnt_t'(s1_end);

    for (int i = 0; i < MaxChars; i++) begin
      pos = cnt_t'(i) - cnt_t'(s1_start);
      if (s1_start && i == 0) begin
        chars_next[i] = CharQuote;
      end else if (pos < cnt_t'(esc_n)) begin
        chars_next[i] = esc[pos[EscIdxW-1:0]];
      end else begin
        chars_next[i] = CharQuote;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= data_valid;
    end
    if (s1_ready) begin
      s1_byte  <= data_byte;
      s1_has   <= has_byte;
      s1_start <= start_of_string;
      s1_end   <= end_of_string;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid && (cnt_next != '0);
    end
    if (s2_ready) begin
      s2_chars <= chars_next;
      s2_cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_idx   <= '0;
    end else if (ser_ready) begin
      ser_valid <= s2_valid;
      ser_idx   <= '0;
    end else if (out_ready) begin
      ser_idx <= ser_idx + idx_t'(1);
    end
    if (ser_ready) begin
      ser_chars <= s2_chars;
      ser_cnt   <= s2_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (out_ready) begin
      char_valid <= ser_valid;
    end
    if (out_ready) begin
      out_char    <= ser_chars[ser_idx];
      last_of_run <= ser_last;
    end
  end

endmodule

>>> rtl/core/jse_checker.sv
module jse_checker (
  input logic       clk,
  input logic       rst,
  input logic       data_stall,
  input logic [7:0] out_char,
  input logic       last_of_run,
  input logic       char_valid,
  input logic       char_stall
);

  // stalled output word holds
  assert property (@(posedge clk) disable iff (rst)
    char_valid && char_stall |=> char_valid && $stable(out_char) && $stable(last_of_run))
    else $error("stalled output word changed");

  // characters of one run go out without gaps
  assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall && !last_of_run |=> char_valid)
    else $error("gap inside an output run");

  assert property (@(posedge clk) rst |=> !char_valid)
    else $error("output valid after reset");

  assert property (@(posedge clk) rst |=> !data_stall)
    else $error("input stalled right after reset");

endmodule

bind json_string_escaper_unit jse_checker u_jse_checker (
  .clk        (clk),
  .rst        (rst),
  .data_stall (data_stall),
  .out_char   (out_char),
  .last_of_run(last_of_run),
  .char_valid (char_valid),
  .char_stall (char_stall)
);
